// ----- rtl/tdss_pkg.sv -----
// Package: widths, state codes and fixed-point helpers for the tridiagonal solver.
`default_nettype none
package tdss_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DVD_W     = DATA_W + FRAC_BITS;
    localparam int QUO_W     = DVD_W + 1;
    localparam int STEP_W    = $clog2(DVD_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULC,
        ST_PIV,
        ST_NUM,
        ST_CHECK,
        ST_DVC_GO,
        ST_DVC_WT,
        ST_DVD_GO,
        ST_DVD_WT,
        ST_WR,
        ST_BS_START,
        ST_BS_RD,
        ST_BS_MUL,
        ST_BS_SUB,
        ST_OUT_RD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                     ovf;
        logic signed [DATA_W-1:0] val;
    } t_sat;

    // Clamp a wide signed value into the data word range.
    function automatic t_sat sat_word(input logic signed [PROD_W-1:0] v);
        t_sat r;
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
        lo = -hi - PROD_W'(64'sd1);
        if (v > hi) begin
            r.ovf = 1'b1;
            r.val = DATA_W'(hi);
        end else if (v < lo) begin
            r.ovf = 1'b1;
            r.val = DATA_W'(lo);
        end else begin
            r.ovf = 1'b0;
            r.val = DATA_W'(v);
        end
        return r;
    endfunction

    // Round a full product to nearest (ties up) and drop the fraction bits.
    function automatic t_sat round_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = (p + (PROD_W'(64'sd1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return sat_word(s);
    endfunction

    // Saturating difference of two data words.
    function automatic t_sat sat_sub(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
        logic signed [PROD_W-1:0] d;
        d = PROD_W'(a) - PROD_W'(b);
        return sat_word(d);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tridiagonal_system_solver_unit.sv -----
// Top level: Thomas-algorithm tridiagonal solver around two coefficient RAMs.
//
//  channel   direction  handshake            word
//  row in    input      start & !busy        sub, diag, super, rhs, row_is_last
//  solution  output     o_valid strobe       index, value, last, singular, overflow
//
// A row holds busy through three multiply/subtract states (skipped for row 0), a
// check, a store and two divisions (48 quotient bits each, plus a start and a finish)
// in the shared divider; a last row runs one division, a zero pivot none.
// A last row then adds back substitution and the emission of one result per row,
// from the highest index down to 0; busy stays high throughout.
// Reset is synchronous, active low; RAM contents are not cleared. Results cannot stall.
`default_nettype none
module tridiagonal_system_solver_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [tdss_pkg::DATA_W-1:0]  i_sub_coef,
    input  wire logic signed [tdss_pkg::DATA_W-1:0]  i_diag_coef,
    input  wire logic signed [tdss_pkg::DATA_W-1:0]  i_super_coef,
    input  wire logic signed [tdss_pkg::DATA_W-1:0]  i_rhs_value,
    input  wire logic                                i_row_is_last,
    output logic                                     o_valid,
    output logic [tdss_pkg::ADDR_W-1:0]              o_unknown_index,
    output logic signed [tdss_pkg::DATA_W-1:0]       o_unknown_value,
    output logic                                     o_result_last,
    output logic                                     o_singular_seen,
    output logic                                     o_overflow_seen
);

    tdss_pkg::t_state r_state, n_state;

    logic signed [tdss_pkg::DATA_W-1:0] r_a, r_b, r_c, r_d;
    logic signed [tdss_pkg::DATA_W-1:0] n_a, n_b, n_c, n_d;
    logic                               r_last, n_last;
    logic [tdss_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic signed [tdss_pkg::DATA_W-1:0] r_prev_c, n_prev_c, r_prev_d, n_prev_d;
    logic signed [tdss_pkg::PROD_W-1:0] r_prod, n_prod;
    logic signed [tdss_pkg::DATA_W-1:0] r_piv, n_piv, r_num, n_num;
    logic signed [tdss_pkg::DATA_W-1:0] r_cp, n_cp, r_dp, n_dp;
    logic signed [tdss_pkg::DATA_W-1:0] r_x, n_x, r_dv, n_dv;
    logic [tdss_pkg::ADDR_W-1:0]        r_idx, n_idx;
    logic                               r_sing, n_sing, r_ovf, n_ovf;

    logic                               c_we, d_we;
    logic [tdss_pkg::ADDR_W-1:0]        waddr, raddr;
    logic [tdss_pkg::DATA_W-1:0]        d_wdata;
    logic [tdss_pkg::DATA_W-1:0]        c_rdata, d_rdata;

    logic                               div_start, div_done;
    logic signed [tdss_pkg::DATA_W-1:0] div_num;
    logic signed [tdss_pkg::QUO_W-1:0]  div_quo;

    tdss_pkg::t_sat                     s_rnd, s_sub, s_quo;

    // Store for modified super-diagonal
    tdss_ram #(.WIDTH(tdss_pkg::DATA_W), .DEPTH(tdss_pkg::MAX_ROWS)) u_c_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (waddr),
        .i_wdata (r_cp),
        .i_raddr (raddr),
        .o_rdata (c_rdata)
    );

    // Store for modified rhs, overwritten by the solution
    tdss_ram #(.WIDTH(tdss_pkg::DATA_W), .DEPTH(tdss_pkg::MAX_ROWS)) u_d_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (waddr),
        .i_wdata (d_wdata),
        .i_raddr (raddr),
        .o_rdata (d_rdata)
    );

    assign div_num = (r_state == tdss_pkg::ST_DVC_GO) ? r_c : r_num;

    tdss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_piv),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdss_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_sing  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sing  <= n_sing;
            r_ovf   <= n_ovf;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_c      <= n_c;
        r_d      <= n_d;
        r_last   <= n_last;
        r_prev_c <= n_prev_c;
        r_prev_d <= n_prev_d;
        r_prod   <= n_prod;
        r_piv    <= n_piv;
        r_num    <= n_num;
        r_cp     <= n_cp;
        r_dp     <= n_dp;
        r_x      <= n_x;
        r_dv     <= n_dv;
        r_idx    <= n_idx;
    end

    // Sequencer: forward sweep, back substitution, emission
    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_d      = r_d;
        n_last   = r_last;
        n_cnt    = r_cnt;
        n_prev_c = r_prev_c;
        n_prev_d = r_prev_d;
        n_prod   = r_prod;
        n_piv    = r_piv;
        n_num    = r_num;
        n_cp     = r_cp;
        n_dp     = r_dp;
        n_x      = r_x;
        n_dv     = r_dv;
        n_idx    = r_idx;
        n_sing   = r_sing;
        n_ovf    = r_ovf;
        c_we     = 1'b0;
        d_we     = 1'b0;
        waddr    = r_cnt[tdss_pkg::ADDR_W-1:0];
        d_wdata  = r_dp;
        raddr    = r_idx;
        div_start = 1'b0;
        o_valid  = 1'b0;
        s_rnd    = tdss_pkg::round_prod(r_prod);
        s_sub    = '0;
        s_quo    = tdss_pkg::sat_word(tdss_pkg::PROD_W'(div_quo));

        case (r_state)
            tdss_pkg::ST_IDLE: begin
                if (start) begin
                    n_a    = i_sub_coef;
                    n_b    = i_diag_coef;
                    n_c    = i_super_coef;
                    n_d    = i_rhs_value;
                    n_last = i_row_is_last;
                    n_piv  = i_diag_coef;
                    n_num  = i_rhs_value;
                    if (r_cnt == tdss_pkg::CNT_W'(tdss_pkg::MAX_ROWS)) begin
                        // drop the row; run back substitution if it ends the system
                        n_ovf = 1'b1;
                        if (i_row_is_last) begin
                            n_state = tdss_pkg::ST_BS_START;
                        end
                    end else if (r_cnt == '0) begin
                        n_state = tdss_pkg::ST_CHECK;
                    end else begin
                        n_state = tdss_pkg::ST_MULC;
                    end
                end
            end
            tdss_pkg::ST_MULC: begin
                n_prod  = r_a * r_prev_c;
                n_state = tdss_pkg::ST_PIV;
            end
            tdss_pkg::ST_PIV: begin
                s_sub   = tdss_pkg::sat_sub(r_b, s_rnd.val);
                n_piv   = s_sub.val;
                n_ovf   = r_ovf | s_rnd.ovf | s_sub.ovf;
                n_prod  = r_a * r_prev_d;
                n_state = tdss_pkg::ST_NUM;
            end
            tdss_pkg::ST_NUM: begin
                s_sub   = tdss_pkg::sat_sub(r_d, s_rnd.val);
                n_num   = s_sub.val;
                n_ovf   = r_ovf | s_rnd.ovf | s_sub.ovf;
                n_state = tdss_pkg::ST_CHECK;
            end
            tdss_pkg::ST_CHECK: begin
                n_cp = '0;
                n_dp = '0;
                if (r_piv == '0) begin
                    n_sing  = 1'b1;
                    n_state = tdss_pkg::ST_WR;
                end else if (!r_last) begin
                    n_state = tdss_pkg::ST_DVC_GO;
                end else begin
                    n_state = tdss_pkg::ST_DVD_GO;
                end
            end
            tdss_pkg::ST_DVC_GO: begin
                div_start = 1'b1;
                n_state   = tdss_pkg::ST_DVC_WT;
            end
            tdss_pkg::ST_DVC_WT: begin
                if (div_done) begin
                    n_cp    = s_quo.val;
                    n_ovf   = r_ovf | s_quo.ovf;
                    n_state = tdss_pkg::ST_DVD_GO;
                end
            end
            tdss_pkg::ST_DVD_GO: begin
                div_start = 1'b1;
                n_state   = tdss_pkg::ST_DVD_WT;
            end
            tdss_pkg::ST_DVD_WT: begin
                if (div_done) begin
                    n_dp    = s_quo.val;
                    n_ovf   = r_ovf | s_quo.ovf;
                    n_state = tdss_pkg::ST_WR;
                end
            end
            tdss_pkg::ST_WR: begin
                // store c' and d' of this row and keep them for the next
                c_we     = 1'b1;
                d_we     = 1'b1;
                n_prev_c = r_cp;
                n_prev_d = r_dp;
                n_cnt    = r_cnt + 1'b1;
                n_state  = r_last ? tdss_pkg::ST_BS_START : tdss_pkg::ST_IDLE;
            end
            tdss_pkg::ST_BS_START: begin
                n_idx   = tdss_pkg::ADDR_W'(r_cnt - 1'b1);
                n_x     = r_prev_d;
                n_state = (r_cnt == tdss_pkg::CNT_W'(1)) ? tdss_pkg::ST_OUT_RD
                                                         : tdss_pkg::ST_BS_RD;
            end
            tdss_pkg::ST_BS_RD: begin
                raddr   = r_idx - 1'b1;
                n_state = tdss_pkg::ST_BS_MUL;
            end
            tdss_pkg::ST_BS_MUL: begin
                n_prod  = $signed(c_rdata) * r_x;
                n_dv    = d_rdata;
                n_state = tdss_pkg::ST_BS_SUB;
            end
            tdss_pkg::ST_BS_SUB: begin
                // x[i-1] = d'[i-1] - c'[i-1] * x[i], written over d'
                s_sub   = tdss_pkg::sat_sub(r_dv, s_rnd.val);
                n_ovf   = r_ovf | s_rnd.ovf | s_sub.ovf;
                n_x     = s_sub.val;
                d_we    = 1'b1;
                waddr   = r_idx - 1'b1;
                d_wdata = s_sub.val;
                n_idx   = r_idx - 1'b1;
                if (r_idx == tdss_pkg::ADDR_W'(1)) begin
                    n_idx   = tdss_pkg::ADDR_W'(r_cnt - 1'b1);
                    n_state = tdss_pkg::ST_OUT_RD;
                end else begin
                    n_state = tdss_pkg::ST_BS_RD;
                end
            end
            tdss_pkg::ST_OUT_RD: begin
                raddr   = r_idx;
                n_state = tdss_pkg::ST_OUT;
            end
            tdss_pkg::ST_OUT: begin
                o_valid = 1'b1;
                if (r_idx == '0) begin
                    // end of run: clear count and flags
                    n_cnt   = '0;
                    n_sing  = 1'b0;
                    n_ovf   = 1'b0;
                    n_state = tdss_pkg::ST_IDLE;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = tdss_pkg::ST_OUT_RD;
                end
            end
            default: begin
                n_state = tdss_pkg::ST_IDLE;
            end
        endcase
    end

    // Result word
    assign busy            = (r_state != tdss_pkg::ST_IDLE);
    assign o_unknown_index = r_idx;
    assign o_unknown_value = d_rdata;
    assign o_result_last   = (r_idx == '0);
    assign o_singular_seen = r_sing;
    assign o_overflow_seen = r_ovf;

endmodule
`default_nettype wire

// ----- rtl/tdss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tdss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/tdss_div.sv -----
// Bit-serial signed divider: (num << FRAC_BITS) / den, truncated toward zero.
`default_nettype none
module tdss_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [tdss_pkg::DATA_W-1:0]  i_num,
    input  wire logic signed [tdss_pkg::DATA_W-1:0]  i_den,
    output logic                                     o_done,
    output logic signed [tdss_pkg::QUO_W-1:0]        o_quo
);

    logic                               r_run;
    logic [tdss_pkg::STEP_W-1:0]        r_step;
    logic [tdss_pkg::DATA_W-1:0]        r_rem;
    logic [tdss_pkg::DVD_W-1:0]         r_quo;
    logic [tdss_pkg::DATA_W-1:0]        r_dsr;
    logic                               r_neg;
    logic                               r_done;
    logic [tdss_pkg::DATA_W-1:0]        num_mag;
    logic [tdss_pkg::DATA_W-1:0]        den_mag;
    logic [tdss_pkg::DATA_W:0]          trial;
    logic [tdss_pkg::DATA_W:0]          shifted;

    assign num_mag = i_num[tdss_pkg::DATA_W-1] ? (~i_num + 1'b1) : i_num;
    assign den_mag = i_den[tdss_pkg::DATA_W-1] ? (~i_den + 1'b1) : i_den;
    assign shifted = {r_rem, r_quo[tdss_pkg::DVD_W-1]};
    assign trial   = shifted - {1'b0, r_dsr};

    // Shift one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 1'b1;
                if (r_step == tdss_pkg::STEP_W'(tdss_pkg::DVD_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {num_mag, {tdss_pkg::FRAC_BITS{1'b0}}};
            r_dsr <= den_mag;
            r_neg <= i_num[tdss_pkg::DATA_W-1] ^ i_den[tdss_pkg::DATA_W-1];
        end else if (r_run) begin
            if (!trial[tdss_pkg::DATA_W]) begin
                r_rem <= trial[tdss_pkg::DATA_W-1:0];
                r_quo <= {r_quo[tdss_pkg::DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[tdss_pkg::DATA_W-1:0];
                r_quo <= {r_quo[tdss_pkg::DVD_W-2:0], 1'b0};
            end
        end
    end

    // Apply sign to the magnitude
    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule
`default_nettype wire

// ----- tb/tb_tridiagonal_system_solver_unit.sv -----
// Testbench for the tridiagonal solver: rows in, solutions checked against a local sweep model.
`timescale 1ns / 100ps
module tb_tridiagonal_system_solver_unit;

    localparam int  LIMIT_CYCLES = 1500000;
    localparam int  CLEAR_CYCLES = 400;
    localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

    typedef logic signed [tdss_pkg::DATA_W-1:0] t_word;

    typedef struct {
        logic [tdss_pkg::ADDR_W-1:0] index;
        t_word                       value;
        logic                        last;
        logic                        singular;
        logic                        overflow;
    } t_solution;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    t_word                       i_sub_coef;
    t_word                       i_diag_coef;
    t_word                       i_super_coef;
    t_word                       i_rhs_value;
    logic                        i_row_is_last;
    logic                        o_valid;
    logic [tdss_pkg::ADDR_W-1:0] o_unknown_index;
    t_word                       o_unknown_value;
    logic                        o_result_last;
    logic                        o_singular_seen;
    logic                        o_overflow_seen;

    // Solver state mirrored from the forward sweep
    t_word cp_store [tdss_pkg::MAX_ROWS];
    t_word dp_store [tdss_pkg::MAX_ROWS];
    int    rows_held;
    bit    singular_flag;
    bit    overflow_flag;

    t_solution solution_queue[$];
    int        error_count;
    longint    cycle_count;

    tridiagonal_system_solver_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sub_coef     (i_sub_coef),
        .i_diag_coef    (i_diag_coef),
        .i_super_coef   (i_super_coef),
        .i_rhs_value    (i_rhs_value),
        .i_row_is_last  (i_row_is_last),
        .o_valid        (o_valid),
        .o_unknown_index(o_unknown_index),
        .o_unknown_value(o_unknown_value),
        .o_result_last  (o_result_last),
        .o_singular_seen(o_singular_seen),
        .o_overflow_seen(o_overflow_seen)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Clamp to the word range and note saturation
    function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v);
        if (v > WORD_MAX) begin
            overflow_flag = 1;
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            overflow_flag = 1;
            return WORD_MIN;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b + (64'sd1 <<< (tdss_pkg::FRAC_BITS - 1));
        return clamp_word(p >>> tdss_pkg::FRAC_BITS);
    endfunction

    function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
                                                  input logic signed [63:0] d);
        logic signed [63:0] q;
        q = (n * (64'sd1 <<< tdss_pkg::FRAC_BITS)) / d;
        return clamp_word(q);
    endfunction

    // Forward-sweep one row; on the last row queue the back-substituted solution
    task automatic solve_row(input t_word a, input t_word b, input t_word c, input t_word d,
                             input logic last);
        logic signed [63:0] pivot, num, cp, dp;
        logic signed [63:0] sol [tdss_pkg::MAX_ROWS];
        t_solution s;
        int n;
        cp = 0;
        dp = 0;
        if (rows_held >= tdss_pkg::MAX_ROWS) begin
            overflow_flag = 1;
            if (!last) return;
        end else begin
            if (rows_held == 0) begin
                pivot = b;
                num = d;
            end else begin
                pivot = clamp_word(64'(b) - fx_mul(a, cp_store[rows_held-1]));
                num   = clamp_word(64'(d) - fx_mul(a, dp_store[rows_held-1]));
            end
            if (pivot == 0) singular_flag = 1;
            else begin
                if (!last) cp = fx_div(c, pivot);
                dp = fx_div(num, pivot);
            end
            cp_store[rows_held] = cp[tdss_pkg::DATA_W-1:0];
            dp_store[rows_held] = dp[tdss_pkg::DATA_W-1:0];
            rows_held++;
            if (!last) return;
        end
        n = rows_held;
        sol[n-1] = dp_store[n-1];
        for (int i = n - 1; i > 0; i--)
            sol[i-1] = clamp_word(64'(dp_store[i-1]) - fx_mul(cp_store[i-1], sol[i]));
        for (int i = n - 1; i >= 0; i--) begin
            s.index = i[tdss_pkg::ADDR_W-1:0];
            s.value = sol[i][tdss_pkg::DATA_W-1:0];
            s.last = (i == 0);
            s.singular = singular_flag;
            s.overflow = overflow_flag;
            solution_queue = {solution_queue, s};
        end
        rows_held = 0;
        singular_flag = 0;
        overflow_flag = 0;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Hold start low for a random gap: mostly short, sometimes long
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
        repeat (n) @(posedge i_clk);
    endtask

    // Send one row word and wait for the accepting edge
    task automatic send_row(input t_word a, input t_word b, input t_word c, input t_word d,
                            input logic last);
        start         <= 1'b1;
        i_sub_coef    <= a;
        i_diag_coef   <= b;
        i_super_coef  <= c;
        i_rhs_value   <= d;
        i_row_is_last <= last;
        // busy only moves at the rising edge, so sample it mid-cycle
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        solve_row(a, b, c, d, last);
        start <= 1'b0;
        @(posedge i_clk);
        idle_gap();
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            3: return $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000;
            default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
        endcase
    endfunction

    // Mostly diagonally dominant rows keep the sweep well conditioned; one in five is fully random
    task automatic send_random_row(input logic last);
        t_word a, b, c, d;
        if ($urandom_range(0, 4) == 0) begin
            a = rand_word(); b = rand_word(); c = rand_word(); d = rand_word();
        end else begin
            a = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            c = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            b = $signed($urandom_range(32'h50000, 32'h200000));
            if ($urandom_range(0, 1)) b = -b;
            d = rand_word();
        end
        send_row(a, b, c, d, last);
    endtask

    task automatic send_system(input int rows);
        for (int r = 0; r < rows; r++) send_random_row(r == rows - 1);
    endtask

    // Check each strobed solution word against the oldest expectation
    always @(negedge i_clk) begin
        t_solution s;
        if (i_rst_n && o_valid) begin
            if (solution_queue.size() == 0) begin
                report_mismatch("unexpected word", o_unknown_index, -1);
            end else begin
                s = solution_queue.pop_front();
                if (o_unknown_index !== s.index) report_mismatch("index", o_unknown_index, s.index);
                if (o_unknown_value !== s.value) report_mismatch("value", o_unknown_value, s.value);
                if (o_result_last !== s.last) report_mismatch("last", o_result_last, s.last);
                if (o_singular_seen !== s.singular)
                    report_mismatch("singular", o_singular_seen, s.singular);
                if (o_overflow_seen !== s.overflow)
                    report_mismatch("overflow", o_overflow_seen, s.overflow);
            end
        end
    end

    // Count cycles and abort on runaway
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // Extremes, single-row systems and zero pivots
    task automatic test_directed();
        send_row(0, 32'sh00010000, 0, 32'sh7fffffff, 1);
        send_row(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1);
        send_row(0, 0, 32'sh00010000, 32'sh00010000, 1);
        send_row(32'sh7fffffff, 32'sh00000001, 32'sh7fffffff, 32'sh7fffffff, 0);
        send_row(32'sh7fffffff, 32'sh00020000, 32'sh80000000, 32'sh80000000, 1);
        send_row(32'sh00010000, 32'sh00040000, 32'sh00010000, 32'sh00050000, 0);
        send_row(32'sh00010000, 32'sh00040000, 32'sh00010000, 32'shfffb0000, 0);
        send_row(32'sh00040000, 32'sh00010000, 32'sh00010000, 32'sh00030000, 1);
        send_row(32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff, 0);
        send_row(0, 0, 0, 0, 1);
    endtask

    // Full-depth system plus overflowing rows, the last one marked last
    task automatic test_too_many_rows();
        send_system(tdss_pkg::MAX_ROWS);
        for (int r = 0; r < tdss_pkg::MAX_ROWS; r++) send_random_row(0);
        send_random_row(0);
        send_random_row(0);
        send_random_row(1);
    endtask

    // Mostly small random systems
    task automatic test_random_systems();
        int sent;
        sent = 0;
        while (sent < 165) begin
            int rows;
            rows = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_system(rows);
            sent += rows;
        end
    endtask

    initial begin
        start = 1'b0;
        i_sub_coef = '0;
        i_diag_coef = '0;
        i_super_coef = '0;
        i_rhs_value = '0;
        i_row_is_last = 1'b0;
        i_rst_n = 1'b0;
        cycle_count = 0;
        error_count = 0;
        rows_held = 0;
        singular_flag = 0;
        overflow_flag = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_too_many_rows();
        test_random_systems();
        while (solution_queue.size() != 0 || busy) @(posedge i_clk);
        repeat (CLEAR_CYCLES) @(posedge i_clk);
        if (error_count == 0 && solution_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/tdss_pkg.sv
rtl/tdss_ram.sv
rtl/tdss_div.sv
rtl/tridiagonal_system_solver_unit.sv
tb/tb_tridiagonal_system_solver_unit.sv
